// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL module of the sorted priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define SPQ_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("assertion failed");

// Same-cycle implication, checked outside of reset.
`define SPQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, checked outside of reset.
`define SPQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ----- rtl/core/spq_pkg.sv -----
// Package with the types and constants of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int PRIO_W    = 8;
	localparam int OCC_W     = 5;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [PRIO_W-1:0] prio_t;

	// Per-cell control from the top level.
	typedef struct packed {
		logic enq;
		logic deq;
		logic valid;
		logic left_keep;
	} cell_ctl_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::value_t    new_value,
	input  spq_pkg::prio_t     new_prio,
	input  spq_pkg::value_t    left_value,
	input  spq_pkg::prio_t     left_prio,
	input  spq_pkg::value_t    right_value,
	input  spq_pkg::prio_t     right_prio,
	output spq_pkg::value_t    value,
	output spq_pkg::prio_t     prio,
	output logic               keep
);
	import spq_pkg::*;

	value_t value_q;
	prio_t  prio_q;

	// An entry stays put when it is served no later than the new item.
	assign keep  = ctl.valid && (prio_q <= new_prio);
	assign value = value_q;
	assign prio  = prio_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && !keep) begin
			if (ctl.left_keep) begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end else begin
				value_q <= left_value;
				prio_q  <= left_prio;
			end
		end else if (ctl.deq) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a row of shifting slot cells.
`timescale 1ns / 1ps

// Bounded priority queue held as a sorted row of DEPTH cells, cell 0 at the
// front. An item is taken at a rising edge where start is high and busy is
// low; busy never rises, so one item can be taken in every cycle. All cells
// compare the new priority with their own in parallel during the cycle of
// acceptance, so an enqueue or dequeue completes within that cycle and its
// result appears on the next cycle with done high for exactly that cycle.
// The receiver cannot stall, so it must take the result when done is high.
// Smaller priority numbers are served first and equal priorities leave in
// arrival order. A dequeue on an empty queue reports underflow, and an
// enqueue into a full queue is dropped and reports overflow. Occupancy gives
// the entry count after the item, in its low five bits.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             kind,
	input  logic signed [spq_pkg::VAL_W-1:0] item_value,
	input  logic [spq_pkg::PRIO_W-1:0]       item_priority,
	output logic                             done,
	output spq_pkg::status_t                 status,
	output logic signed [spq_pkg::VAL_W-1:0] out_value,
	output logic [spq_pkg::OCC_W-1:0]        occupancy
);
	import spq_pkg::*;

	`include "assert_macros.svh"

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          done_q;
	status_t       status_q;
	value_t        out_value_q;

	logic accept;
	logic enq_ok;
	logic deq_ok;

	value_t     cell_value [DEPTH];
	prio_t      cell_prio  [DEPTH];
	logic [DEPTH:0] keep_c;

	// Every item completes in its own cycle, so the block is never busy.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign enq_ok = accept && (kind == KIND_ENQ) && (count_q != CW'(DEPTH));
	assign deq_ok = accept && (kind == KIND_DEQ) && (count_q != '0);

	// The front cell always sees a keeping neighbor, so it takes the new item
	// when it does not keep its own entry.
	assign keep_c[0] = 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		value_t    left_value;
		prio_t     left_prio;
		value_t    right_value;
		prio_t     right_prio;

		assign ctl.enq       = enq_ok;
		assign ctl.deq       = deq_ok;
		assign ctl.valid     = (count_q > CW'(i));
		assign ctl.left_keep = keep_c[i];

		if (i == 0) begin : g_first
			assign left_value = item_value;
			assign left_prio  = item_priority;
		end else begin : g_mid
			assign left_value = cell_value[i-1];
			assign left_prio  = cell_prio[i-1];
		end

		// The last cell refills from itself on a dequeue; it falls out of
		// the valid range anyway.
		if (i == DEPTH - 1) begin : g_last
			assign right_value = cell_value[i];
			assign right_prio  = cell_prio[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
			assign right_prio  = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_value  (item_value),
			.new_prio   (item_priority),
			.left_value (left_value),
			.left_prio  (left_prio),
			.right_value(right_value),
			.right_prio (right_prio),
			.value      (cell_value[i]),
			.prio       (cell_prio[i]),
			.keep       (keep_c[i+1])
		);
	end

	// Entry count and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (enq_ok) begin
				count_q <= count_q + 1'b1;
			end else if (deq_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Result payload, captured with the item.
	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (kind == KIND_ENQ && !enq_ok) begin
				status_q    <= ST_OVERFLOW;
				out_value_q <= '0;
			end else if (kind == KIND_DEQ && !deq_ok) begin
				status_q    <= ST_UNDERFLOW;
				out_value_q <= '0;
			end else if (deq_ok) begin
				status_q    <= ST_OK;
				out_value_q <= cell_value[0];
			end else begin
				status_q    <= ST_OK;
				out_value_q <= '0;
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_value = out_value_q;
	// The count register already holds the value after the item.
	assign occupancy = OCC_W'(32'(count_q));

	`SPQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
	`SPQ_ASSERT_NXT(a_done_follows, accept, done)
	`SPQ_ASSERT_NXT(a_enq_count, enq_ok, count_q == $past(count_q) + 1'b1)
	`SPQ_ASSERT_IMP(a_underflow_empty, done && status == ST_UNDERFLOW, count_q == '0)
	`SPQ_ASSERT_IMP(a_front_sorted, count_q >= CW'(2), cell_prio[0] <= cell_prio[1])

endmodule

// ----- dv/spq_checker.sv -----
// Checker that predicts the priority queue's results and compares them as they arrive.
`timescale 1ns / 1ps

module spq_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      kind,
	input  spq_pkg::value_t           item_value,
	input  spq_pkg::prio_t            item_priority,
	input  logic                      done,
	input  spq_pkg::status_t          status,
	input  spq_pkg::value_t           out_value,
	input  logic [spq_pkg::OCC_W-1:0] occupancy,
	output int                        error_count,
	output int                        results_owed
);

	import spq_pkg::*;

	typedef struct packed {
		status_t           status;
		value_t            value;
		logic [OCC_W-1:0]  occ;
	} queue_result_t;

	// Shadow copy of the queue, slot 0 served next.
	value_t        slot_value [DEPTH];
	prio_t         slot_prio [DEPTH];
	int            held;
	queue_result_t expected_results [$];
	queue_result_t want;

	initial begin
		error_count = 0;
		results_owed = 0;
		held = 0;
	end

	// Applies one item to the shadow queue and gives the result it should produce.
	task automatic queue_operation(input logic op, input value_t v, input prio_t p,
			output queue_result_t r);
		int pos;
		r.status = ST_OK;
		r.value = '0;
		if (op == KIND_ENQ) begin
			if (held >= DEPTH) begin
				r.status = ST_OVERFLOW;
			end else begin
				// Equal priorities go behind the ones already held.
				pos = 0;
				while (pos < held && slot_prio[pos] <= p)
					pos++;
				for (int i = held; i > pos; i--) begin
					slot_value[i] = slot_value[i-1];
					slot_prio[i] = slot_prio[i-1];
				end
				slot_value[pos] = v;
				slot_prio[pos] = p;
				held++;
			end
		end else begin
			if (held == 0) begin
				r.status = ST_UNDERFLOW;
			end else begin
				r.value = slot_value[0];
				for (int i = 1; i < held; i++) begin
					slot_value[i-1] = slot_value[i];
					slot_prio[i-1] = slot_prio[i];
				end
				held--;
			end
		end
		r.occ = held[OCC_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			expected_results.delete();
			results_owed <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, %s %0d %s %0d %s %0d",
						$time, "actual status", status, "value", out_value,
						"occupancy", occupancy);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, status);
						error_count++;
					end
					if (out_value !== want.value) begin
						$display("%0t: out_value mismatch: expected %0d, actual %0d",
							$time, want.value, out_value);
						error_count++;
					end
					if (occupancy !== want.occ) begin
						$display("%0t: occupancy mismatch: expected %0d, actual %0d",
							$time, want.occ, occupancy);
						error_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				queue_operation(kind, item_value, item_priority, want);
				expected_results.push_back(want);
			end
			results_owed <= expected_results.size();
		end
	end

endmodule

// ----- dv/sorted_priority_queue_tb.sv -----
// Top of the priority queue testbench: clock, reset, item stimulus and the verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

	import spq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int ITEM_TARGET  = 1400;
	localparam int MAX_GAP      = 13;
	// The longest quiet stretch in a correct run barely exceeds one sender gap,
	// so this limit leaves a wide margin.
	localparam int STALL_LIMIT  = 200;
	// The result arrives in the cycle after its item; the drain cycles catch strays.
	localparam int DRAIN_CYCLES = 4;

	// All inputs of the block hold known values from time zero.
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             kind = KIND_ENQ;
	value_t           item_value = '0;
	prio_t            item_priority = '0;

	logic             busy;
	logic             done;
	status_t          status;
	value_t           out_value;
	logic [OCC_W-1:0] occupancy;

	int error_count;
	int results_owed;
	int items_sent = 0;
	int idle_cycles = 0;

	// Stimulus working variables.
	int     seg_len;
	int     enq_pct;
	int     prio_mode;
	bit     quiet;
	logic   op;
	prio_t  p;

	always #2 clk = ~clk;

	sorted_priority_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.item_value   (item_value),
		.item_priority(item_priority),
		.done         (done),
		.status       (status),
		.out_value    (out_value),
		.occupancy    (occupancy)
	);

	spq_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.item_value   (item_value),
		.item_priority(item_priority),
		.done         (done),
		.status       (status),
		.out_value    (out_value),
		.occupancy    (occupancy),
		.error_count  (error_count),
		.results_owed (results_owed)
	);

	// The watchdog restarts whenever an item or a result moves. If neither
	// moves for too long, the block has hung and the run ends as a failure.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Data words lean toward the extremes now and then, so that the sign bit
	// and the all-ones and all-zeros patterns show up often.
	function automatic value_t pick_value();
		case ($urandom_range(0, 11))
			0: pick_value = 32'sh7FFF_FFFF;
			1: pick_value = 32'sh8000_0000;
			2: pick_value = '0;
			3: pick_value = '1;
			default: pick_value = $urandom;
		endcase
	endfunction

	// Presents one item and holds it until the block takes it. The task is
	// entered right after a rising edge. Start is lowered only when a gap
	// follows, so back-to-back items keep it high without a glitch.
	task automatic send_item(input logic k, input value_t v, input prio_t pr, input int gap);
		kind <= k;
		item_value <= v;
		item_priority <= pr;
		start <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		items_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		// Reset is held from time zero and released on a rising edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A dequeue on the empty queue must report underflow,
		// whatever its unused fields hold.
		send_item(KIND_DEQ, pick_value(), prio_t'($urandom_range(0, 255)),
			$urandom_range(0, MAX_GAP));
		// Extreme words and priorities, then a tie at priority zero, which must
		// leave in arrival order.
		send_item(KIND_ENQ, 32'sh7FFF_FFFF, 8'hFF, $urandom_range(0, MAX_GAP));
		send_item(KIND_ENQ, 32'sh8000_0000, 8'h00, $urandom_range(0, MAX_GAP));
		send_item(KIND_ENQ, '0, 8'h00, $urandom_range(0, MAX_GAP));
		// Fill the rest of the queue with a few priorities that repeat, so that
		// ties sit in the middle and at the back as well.
		for (int i = 0; i < DEPTH - 3; i++)
			send_item(KIND_ENQ, pick_value(), prio_t'((i % 4) * 85), $urandom_range(0, MAX_GAP));
		// An enqueue into the full queue is dropped, even at the best priority.
		send_item(KIND_ENQ, pick_value(), 8'h00, $urandom_range(0, MAX_GAP));
		// Dequeues from the full queue, including back-to-back ones.
		for (int i = 0; i < 4; i++)
			send_item(KIND_DEQ, pick_value(), prio_t'($urandom_range(0, 255)),
				(i < 2) ? 0 : 3);

		// Random part in segments. Each segment leans toward enqueue, dequeue or
		// neither, so the queue keeps swinging between empty and full. Narrow
		// priority ranges make ties common; some segments run without gaps.
		while (items_sent < ITEM_TARGET) begin
			seg_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: enq_pct = 15;
				1: enq_pct = 50;
				default: enq_pct = 85;
			endcase
			prio_mode = $urandom_range(0, 2);
			quiet = ($urandom_range(0, 3) == 0);
			repeat (seg_len) begin
				op = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
				case (prio_mode)
					0: p = prio_t'($urandom_range(0, 255));
					1: p = prio_t'($urandom_range(0, 3));
					default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				endcase
				send_item(op, pick_value(), p, quiet ? 0 : $urandom_range(0, MAX_GAP));
			end
		end

		// Wait for every outstanding result, then drain for strays.
		start <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
